### sv/tdfn_pkg.sv
// Package for the triangle de-indexing face normal block.
// Holds command codes, status codes and the face job type, which is also the queue entry type.
// No dependencies.
package tdfn_pkg;

    localparam logic [1:0] CMD_VERTEX = 2'd0;
    localparam logic [1:0] CMD_NORMAL = 2'd1;
    localparam logic [1:0] CMD_FACE   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_DEGEN  = 2'd2;

    // One face job handed from the front part to the back part.
    typedef struct packed {
        logic        bad;       // some index out of range
        logic        indexed;   // normal source for this face
        logic [10:0] vi0;
        logic [10:0] vi1;
        logic [10:0] vi2;
        logic [10:0] ni0;
        logic [10:0] ni1;
        logic [10:0] ni2;
    } face_job_t;

endpackage

### sv/tdfn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tdfn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/tdfn_front.sv
// Front part: accepts items, loads the tables, checks face indices, queues face jobs.
// Depends on tdfn_pkg.
module tdfn_front #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_NORMALS  = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               cmd,
    input  logic [65:0]              indices,
    input  logic                     normal_source,
    output logic                     job_valid,
    input  logic                     job_ready,
    output tdfn_pkg::face_job_t      job,
    output logic                     v_we,
    output logic [$clog2(MAX_VERTICES)-1:0] v_waddr,
    output logic                     n_we,
    output logic [$clog2(MAX_NORMALS)-1:0]  n_waddr
);
    import tdfn_pkg::*;

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int NAW = $clog2(MAX_NORMALS);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int NCW = $clog2(MAX_NORMALS + 1);
    localparam int QD  = 2;

    logic [VCW-1:0] vcount_reg, vcount_next;
    logic [NCW-1:0] ncount_reg, ncount_next;
    face_job_t      q_reg [QD];
    logic [1:0]     qcnt_reg, qcnt_next;
    logic           qwr_reg, qrd_reg;
    logic           fire, push, pop;
    logic [10:0]    vi [3];
    logic [10:0]    ni [3];
    logic           bad;
    face_job_t      new_job;

    assign in_ready  = (qcnt_reg != 2'(QD));
    assign fire      = in_valid && in_ready;
    assign job_valid = (qcnt_reg != 2'd0);
    assign job       = q_reg[qrd_reg];
    assign pop       = job_valid && job_ready;
    assign push      = fire && (cmd == CMD_FACE);

    always_comb
    begin
        bad = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            vi[k] = indices[11*k +: 11];
            ni[k] = indices[33 + 11*k +: 11];
            if (vi[k] == 11'd0 || 32'(vi[k]) > 32'(vcount_reg))
            begin
                bad = 1'b1;
            end
            if (normal_source && (ni[k] == 11'd0 || 32'(ni[k]) > 32'(ncount_reg)))
            begin
                bad = 1'b1;
            end
        end
        new_job = '{bad: bad, indexed: normal_source, vi0: vi[0], vi1: vi[1],
                    vi2: vi[2], ni0: ni[0], ni1: ni[1], ni2: ni[2]};
    end

    assign v_we    = fire && (cmd == CMD_VERTEX) && (32'(vcount_reg) < MAX_VERTICES);
    assign n_we    = fire && (cmd == CMD_NORMAL) && (32'(ncount_reg) < MAX_NORMALS);
    assign v_waddr = vcount_reg[VAW-1:0];
    assign n_waddr = ncount_reg[NAW-1:0];

    always_comb
    begin
        vcount_next = vcount_reg + VCW'(v_we);
        ncount_next = ncount_reg + NCW'(n_we);
        qcnt_next   = qcnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            ncount_reg <= '0;
            qcnt_reg   <= '0;
            qwr_reg    <= 1'b0;
            qrd_reg    <= 1'b0;
        end
        else
        begin
            vcount_reg <= vcount_next;
            ncount_reg <= ncount_next;
            qcnt_reg   <= qcnt_next;
            if (push)
            begin
                qwr_reg <= ~qwr_reg;
            end
            if (pop)
            begin
                qrd_reg <= ~qrd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[qwr_reg] <= new_job;
        end
    end

    // Queue never overflows or takes a push when full, and the vertex count stays within capacity.
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) qcnt_reg <= 2'(QD))
        else $error("job queue overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (qcnt_reg == 2'(QD)) |-> !push)
        else $error("push into full queue");
    a_vcount_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(vcount_reg) <= MAX_VERTICES)
        else $error("vertex count past capacity");
endmodule

### sv/tdfn_back.sv
// Back part: reads the tables, forms the face normal with an iterative unit, emits corners.
// Depends on tdfn_pkg.
module tdfn_back #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_NORMALS  = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  tdfn_pkg::face_job_t      job,
    output logic [$clog2(MAX_VERTICES)-1:0] v_raddr,
    input  logic [47:0]              v_rdata,
    output logic [$clog2(MAX_NORMALS)-1:0]  n_raddr,
    input  logic [47:0]              n_rdata,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [111:0]             out_data,
    output logic [1:0]               out_status,
    output logic                     out_last
);
    import tdfn_pkg::*;

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int NAW = $clog2(MAX_NORMALS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_CAP   = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_CRS   = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_SQ    = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_RHS   = 4'd9;
    localparam logic [3:0] S_TRY   = 4'd10;
    localparam logic [3:0] S_TST   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0]        state_reg;
    face_job_t         job_reg;
    logic [1:0]        rd_reg;      // read slot in flight
    logic [1:0]        cap_reg;     // capture slot
    logic [47:0]       p_reg [3];
    logic [47:0]       nrm_reg [3];
    logic signed [16:0] u_reg [3];
    logic signed [16:0] w_reg [3];
    logic signed [33:0] pr_reg [6];
    logic [34:0]       m_reg [3];
    logic              neg_reg [3];
    logic [31:0]       sq_reg [3];
    logic [33:0]       s_reg;
    logic [1:0]        comp_reg;    // component being normalized
    logic [3:0]        bit_reg;
    logic [14:0]       q_reg;
    logic [59:0]       rhs_reg;
    logic [29:0]       tt_reg;
    logic [15:0]       fn_reg [3];
    logic [1:0]        st_reg;
    logic [1:0]        corner_reg;
    logic              ovalid_reg;
    logic [111:0]      odata_reg;
    logic [1:0]        ostat_reg;
    logic              olast_reg;
    logic [14:0]       t_try;
    logic [63:0]       tts;
    logic [10:0]       vsel, nsel;
    logic [47:0]       pc, nc;
    logic [15:0]       nx, ny, nz;

    assign job_ready  = (state_reg == S_IDLE);
    assign out_valid  = ovalid_reg;
    assign out_data   = odata_reg;
    assign out_status = ostat_reg;
    assign out_last   = olast_reg;

    always_comb
    begin
        unique case (rd_reg)
            2'd0:    begin vsel = job_reg.vi0; nsel = job_reg.ni0; end
            2'd1:    begin vsel = job_reg.vi1; nsel = job_reg.ni1; end
            default: begin vsel = job_reg.vi2; nsel = job_reg.ni2; end
        endcase
    end
    assign v_raddr = VAW'(vsel - 11'd1);
    assign n_raddr = NAW'(nsel - 11'd1);

    assign t_try = q_reg | (15'd1 << bit_reg);
    assign tts   = 64'(tt_reg) * 64'(s_reg);

    always_comb
    begin
        pc = p_reg[corner_reg];
        if (job_reg.indexed)
        begin
            nc = nrm_reg[corner_reg];
        end
        else
        begin
            nc = {fn_reg[2], fn_reg[1], fn_reg[0]};
        end
        if (job_reg.bad)
        begin
            pc = '0;
            nc = '0;
        end
        {nz, ny, nx} = nc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            // Load a new corner when the output slot is free, drop it once taken.
            if (state_reg == S_EMIT && (!ovalid_reg || out_ready))
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= job.bad ? S_EMIT : S_READ;
                    end
                end
                S_READ:  state_reg <= (rd_reg == 2'd2) ? S_CAP : S_READ;
                S_CAP:
                begin
                    if (cap_reg == 2'd2)
                    begin
                        state_reg <= job_reg.indexed ? S_EMIT : S_DIFF;
                    end
                end
                S_DIFF:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_CRS;
                S_CRS:   state_reg <= S_SHIFT;
                S_SHIFT:
                begin
                    if (m_reg[0] == '0 && m_reg[1] == '0 && m_reg[2] == '0)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (m_reg[0][34:16] == '0 && m_reg[1][34:16] == '0
                             && m_reg[2][34:16] == '0)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:    state_reg <= S_SUM;
                S_SUM:   state_reg <= S_RHS;
                S_RHS:   state_reg <= S_TRY;
                S_TRY:   state_reg <= S_TST;
                S_TST:
                begin
                    if (bit_reg != 4'd0)
                    begin
                        state_reg <= S_TRY;
                    end
                    else if (comp_reg == 2'd2)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_RHS;
                    end
                end
                S_EMIT:
                begin
                    if ((!ovalid_reg || out_ready) && corner_reg == 2'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg    <= job;
                rd_reg     <= 2'd0;
                cap_reg    <= 2'd0;
                corner_reg <= 2'd0;
                st_reg     <= job.bad ? ST_RANGE : ST_OK;
            end
            S_READ:
            begin
                rd_reg <= rd_reg + 2'd1;
                if (rd_reg != 2'd0)
                begin
                    p_reg[rd_reg - 2'd1]   <= v_rdata;
                    nrm_reg[rd_reg - 2'd1] <= n_rdata;
                end
            end
            S_CAP:
            begin
                p_reg[2]   <= v_rdata;
                nrm_reg[2] <= n_rdata;
                cap_reg    <= 2'd2;
            end
            S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    u_reg[k] <= 17'(signed'(p_reg[1][16*k +: 16]))
                              - 17'(signed'(p_reg[0][16*k +: 16]));
                    w_reg[k] <= 17'(signed'(p_reg[2][16*k +: 16]))
                              - 17'(signed'(p_reg[0][16*k +: 16]));
                end
            end
            S_MUL:
            begin
                pr_reg[0] <= u_reg[1] * w_reg[2];
                pr_reg[1] <= u_reg[2] * w_reg[1];
                pr_reg[2] <= u_reg[2] * w_reg[0];
                pr_reg[3] <= u_reg[0] * w_reg[2];
                pr_reg[4] <= u_reg[0] * w_reg[1];
                pr_reg[5] <= u_reg[1] * w_reg[0];
            end
            S_CRS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    logic signed [34:0] cv;
                    cv = 35'(pr_reg[2*k]) - 35'(pr_reg[2*k+1]);
                    neg_reg[k] <= cv[34];
                    m_reg[k]   <= cv[34] ? 35'(-cv) : 35'(cv);
                end
            end
            S_SHIFT:
            begin
                if (m_reg[0] == '0 && m_reg[1] == '0 && m_reg[2] == '0)
                begin
                    st_reg <= ST_DEGEN;
                    for (int k = 0; k < 3; k++)
                    begin
                        fn_reg[k] <= '0;
                    end
                end
                else if (m_reg[0][34:16] != '0 || m_reg[1][34:16] != '0
                         || m_reg[2][34:16] != '0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        m_reg[k] <= m_reg[k] >> 1;
                    end
                end
            end
            S_SQ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    sq_reg[k] <= m_reg[k][15:0] * m_reg[k][15:0];
                end
                comp_reg <= 2'd0;
            end
            S_SUM:   s_reg <= 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2]);
            S_RHS:
            begin
                rhs_reg <= 60'(sq_reg[comp_reg]) << 28;
                q_reg   <= '0;
                bit_reg <= 4'd14;
            end
            S_TRY:   tt_reg <= t_try * t_try;
            S_TST:
            begin
                logic [14:0] qn;
                qn = (tts <= 64'(rhs_reg)) ? t_try : q_reg;
                q_reg   <= qn;
                bit_reg <= bit_reg - 4'd1;
                if (bit_reg == 4'd0)
                begin
                    fn_reg[comp_reg] <= neg_reg[comp_reg] ? 16'(-{1'b0, qn})
                                                         : {1'b0, qn};
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    logic [10:0] vc;
                    unique case (corner_reg)
                        2'd0:    vc = job_reg.vi0;
                        2'd1:    vc = job_reg.vi1;
                        default: vc = job_reg.vi2;
                    endcase
                    odata_reg <= {6'd0,
                                  job_reg.bad ? 10'd0 : 10'(vc - 11'd1),
                                  nz, ny, nx, pc[47:32], pc[31:16], pc[15:0]};
                    ostat_reg  <= st_reg;
                    olast_reg  <= (corner_reg == 2'd2);
                    corner_reg <= corner_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // A result is never overwritten while it waits.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |=> (ovalid_reg && $stable(odata_reg)))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !job_ready)
        else $error("job taken while busy");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |=> ($stable(olast_reg) && $stable(ostat_reg)))
        else $error("last flag or status changed under stall");
    a_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (corner_reg != 2'd3))
        else $error("corner count overrun");
endmodule

### sv/triangle_deindex_face_normal_top.sv
// Top level of the triangle de-indexing face normal block.
// Depends on tdfn_pkg, tdfn_ram, tdfn_front and tdfn_back.
//
// channel   | dir | signals                       | payload
// s_axis    | in  | s_axis_tvalid/tready/tdata    | coords, corner and normal indices
//           |     | s_axis_tuser                  | cmd
// m_axis    | out | m_axis_tvalid/tready/tdata    | pos, norm, elem_index; tlast
//           |     | m_axis_tuser                  | status
// cfg       | in  | cfg_valid/cfg_ready/cfg_data  | normal_source
//
// Once a face leaves the job queue the back part goes straight to emitting on a bad
// index, and reads and captures the corners in indexed mode. Generated mode adds
// differences, products, the cross product, prescale shifts to 16 bits, squares and a sum,
// then the shared square-root-and-divide unit tests one result bit at a time, 15 per component.
// Reset clears counts, the normal source and control; table contents stay undefined.
// A two-entry job queue lets the front keep loading while the back is stalled,
// until two faces wait; low m_axis_tready stalls the back part only while a result waits.
module triangle_deindex_face_normal_top #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_NORMALS  = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coord_x[15:0], coord_y[31:16], coord_z[47:32], corner_a..c[80:48],
    // normal_a..c[113:81], zero pad to 120
    input  logic [119:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, elem_index[105:96],
    // zero pad to 112
    output logic [111:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);
    import tdfn_pkg::*;

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int NAW = $clog2(MAX_NORMALS);

    logic            nsrc_reg;
    logic            job_valid, job_ready;
    face_job_t       job;
    logic            v_we, n_we;
    logic [VAW-1:0]  v_waddr, v_raddr;
    logic [NAW-1:0]  n_waddr, n_raddr;
    logic [47:0]     v_rdata, n_rdata;

    assign cfg_ready = 1'b1;

    // Hold the normal source; the sender must write it only while idle (the block does not enforce this).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsrc_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            nsrc_reg <= cfg_data;
        end
    end

    tdfn_front #(.MAX_VERTICES(MAX_VERTICES), .MAX_NORMALS(MAX_NORMALS)) u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .cmd(s_axis_tuser),
        .indices(s_axis_tdata[113:48]), .normal_source(nsrc_reg),
        .job_valid, .job_ready, .job,
        .v_we, .v_waddr, .n_we, .n_waddr
    );

    tdfn_ram #(.WIDTH(48), .DEPTH(MAX_VERTICES)) u_vram (
        .clk, .we(v_we), .waddr(v_waddr), .wdata(s_axis_tdata[47:0]),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    tdfn_ram #(.WIDTH(48), .DEPTH(MAX_NORMALS)) u_nram (
        .clk, .we(n_we), .waddr(n_waddr), .wdata(s_axis_tdata[47:0]),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    tdfn_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_NORMALS(MAX_NORMALS)) u_back (
        .clk, .rst_n,
        .job_valid, .job_ready, .job,
        .v_raddr, .v_rdata, .n_raddr, .n_rdata,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_status(m_axis_tuser), .out_last(m_axis_tlast)
    );
endmodule

### dv/tdfn_checker.sv
// Checker for the triangle de-indexing face normal block: watches the item,
// result and register channels, predicts every corner and compares. Uses tdfn_pkg.
`timescale 1ns / 100ps

module tdfn_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_data,
    output int           fail_count,
    output int           corners_pending
);
    import tdfn_pkg::*;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } coord_t;

    typedef struct packed {
        logic        last;
        logic [1:0]  status;
        logic [9:0]  elem;
        coord_t      nrm;
        coord_t      pos;
    } corner_t;

    coord_t  vtx_table [1024];
    coord_t  nrm_table [1024];
    int      vtx_count;
    int      nrm_count;
    logic    use_stored;
    corner_t corner_q [$];

    function automatic logic [15:0] unit_comp(longint unsigned m, longint unsigned s,
                                              logic neg);
        longint unsigned q;
        longint unsigned t;
        q = 0;
        for (int b = 14; b >= 0; b--)
        begin
            t = q | (64'd1 << b);
            if (t * t * s <= ((m * m) << 28))
                q = t;
        end
        return neg ? -q[15:0] : q[15:0];
    endfunction

    // Returns 0 for a zero cross product.
    function automatic logic flat_normal(coord_t a, coord_t b, coord_t c, output coord_t n);
        longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
        longint unsigned mx, my, mz, mmax, s;
        ux = $signed(b.x) - $signed(a.x);
        uy = $signed(b.y) - $signed(a.y);
        uz = $signed(b.z) - $signed(a.z);
        wx = $signed(c.x) - $signed(a.x);
        wy = $signed(c.y) - $signed(a.y);
        wz = $signed(c.z) - $signed(a.z);
        cx = uy * wz - uz * wy;
        cy = uz * wx - ux * wz;
        cz = ux * wy - uy * wx;
        n = '0;
        mx = cx < 0 ? -cx : cx;
        my = cy < 0 ? -cy : cy;
        mz = cz < 0 ? -cz : cz;
        if (mx == 0 && my == 0 && mz == 0)
            return 1'b0;
        mmax = mx > my ? mx : my;
        if (mz > mmax)
            mmax = mz;
        while (mmax >= 65536)
        begin
            mx >>= 1;
            my >>= 1;
            mz >>= 1;
            mmax >>= 1;
        end
        s = mx * mx + my * my + mz * mz;
        n.x = unit_comp(mx, s, cx < 0);
        n.y = unit_comp(my, s, cy < 0);
        n.z = unit_comp(mz, s, cz < 0);
        return 1'b1;
    endfunction

    function automatic logic idx_valid(int idx, int count);
        return idx >= 1 && idx <= count;
    endfunction

    task automatic predict_item(logic [1:0] op, logic [119:0] d);
        coord_t     c;
        int         vi [3];
        int         ni [3];
        logic       ok;
        coord_t     fn;
        logic [1:0] st;
        corner_t    r;
        c.x = d[15:0];
        c.y = d[31:16];
        c.z = d[47:32];
        for (int k = 0; k < 3; k++)
        begin
            vi[k] = d[48 + 11 * k +: 11];
            ni[k] = d[81 + 11 * k +: 11];
        end
        if (op == CMD_VERTEX)
        begin
            if (vtx_count < 1024)
                vtx_table[vtx_count++] = c;
        end
        else if (op == CMD_NORMAL)
        begin
            if (nrm_count < 1024)
                nrm_table[nrm_count++] = c;
        end
        else if (op == CMD_FACE)
        begin
            ok = 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                if (!idx_valid(vi[k], vtx_count))
                    ok = 1'b0;
                if (use_stored && !idx_valid(ni[k], nrm_count))
                    ok = 1'b0;
            end
            fn = '0;
            st = ST_OK;
            if (ok && !use_stored
                && !flat_normal(vtx_table[vi[0] - 1], vtx_table[vi[1] - 1],
                                vtx_table[vi[2] - 1], fn))
                st = ST_DEGEN;
            for (int k = 0; k < 3; k++)
            begin
                r = '0;
                r.last = (k == 2);
                if (!ok)
                    r.status = ST_RANGE;
                else
                begin
                    r.status = st;
                    r.pos = vtx_table[vi[k] - 1];
                    r.nrm = use_stored ? nrm_table[ni[k] - 1] : fn;
                    r.elem = vi[k] - 1;
                end
                corner_q.insert(corner_q.size(), r);
            end
        end
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic check_corner(logic [111:0] d, logic [1:0] stat, logic lst);
        corner_t w;
        if (corner_q.size() == 0)
        begin
            report("unexpected corner", d[105:96], 0);
            return;
        end
        w = corner_q.pop_front();
        if (d[15:0] !== w.pos.x) report("pos_x", d[15:0], w.pos.x);
        if (d[31:16] !== w.pos.y) report("pos_y", d[31:16], w.pos.y);
        if (d[47:32] !== w.pos.z) report("pos_z", d[47:32], w.pos.z);
        if (d[63:48] !== w.nrm.x) report("norm_x", d[63:48], w.nrm.x);
        if (d[79:64] !== w.nrm.y) report("norm_y", d[79:64], w.nrm.y);
        if (d[95:80] !== w.nrm.z) report("norm_z", d[95:80], w.nrm.z);
        if (d[105:96] !== w.elem) report("elem_index", d[105:96], w.elem);
        if (stat !== w.status) report("status", stat, w.status);
        if (lst !== w.last) report("tlast", lst, w.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_count <= 0;
            nrm_count <= 0;
            use_stored <= 1'b0;
            fail_count <= 0;
            corner_q.delete();
            corners_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                use_stored = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                predict_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_corner(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            corners_pending = corner_q.size();
        end
    end
endmodule

### dv/triangle_deindex_face_normal_top_test.sv
// Testbench top for triangle_deindex_face_normal_top: drives items, register writes
// and result stalls; tdfn_checker does the prediction. Uses tdfn_pkg.
`timescale 1ns / 100ps

module triangle_deindex_face_normal_top_test;
    import tdfn_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;   // coord_x/y/z, corner_a..c, normal_a..c
    logic [1:0]   s_axis_tuser;   // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;   // pos_x/y/z, norm_x/y/z, elem_index
    logic [1:0]   m_axis_tuser;   // status
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;
    int           fail_count;
    int           corners_pending;
    int           cycle_count;
    logic         quiet_tail;     // no idling near the end of the run
    int           vtx_loaded;
    int           nrm_loaded;

    triangle_deindex_face_normal_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tdfn_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .corners_pending(corners_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous watchdog: ~460 items, the face work behind them, plus stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random stall bursts, ready held high in the tail.
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Present one item and hold it until accepted; valid stays high for the next one.
    task automatic send_item(logic [1:0] op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             int ca, int cb, int cc, int na, int nb, int nc);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tdata <= {6'd0, nc[10:0], nb[10:0], na[10:0], cc[10:0], cb[10:0], ca[10:0],
                         z, y, x};
        s_axis_tuser <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op == CMD_VERTEX && vtx_loaded < 1024)
            vtx_loaded++;
        if (op == CMD_NORMAL && nrm_loaded < 1024)
            nrm_loaded++;
    endtask

    // Drop valid and hold off until every expected corner has come out.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (corners_pending != 0)
            @(posedge clk);
    endtask

    task automatic load_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send_item(CMD_VERTEX, x, y, z, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic load_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        send_item(CMD_NORMAL, x, y, z, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic send_face(int ca, int cb, int cc, int na, int nb, int nc);
        send_item(CMD_FACE, 16'($urandom), 16'($urandom), 16'($urandom),
                  ca, cb, cc, na, nb, nc);
    endtask

    // Index mostly in range, sometimes zero or past the count.
    function automatic int pick_index(int count);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(count + 1, 2047);
        if (r == 2) return count;
        return $urandom_range(1, count);
    endfunction

    // Drain all results, let the block settle, then write the register.
    task automatic write_source(logic stored);
        wait_drain();
        repeat (120) @(posedge clk);
        cfg_data <= stored;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                load_vertex(16'($urandom), 16'($urandom), 16'($urandom));
            else if (r == 1)
                load_normal(16'($urandom), 16'($urandom), 16'($urandom));
            else if (r == 2)
                send_item(CMD_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_face(pick_index(vtx_loaded), pick_index(vtx_loaded),
                          pick_index(vtx_loaded), pick_index(nrm_loaded),
                          pick_index(nrm_loaded), pick_index(nrm_loaded));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        cycle_count = 0;
        quiet_tail = 1'b0;
        vtx_loaded = 0;
        nrm_loaded = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: faces before any load are out of range.
        send_face(1, 1, 1, 1, 1, 1);
        load_vertex(16'h0000, 16'h0000, 16'h0000);
        load_vertex(16'h7fff, 16'h8000, 16'h7fff);
        load_vertex(16'h8000, 16'h7fff, 16'h8000);
        load_vertex(16'h0100, 16'h0000, 16'h0000);
        load_vertex(16'h0000, 16'h0100, 16'h0000);
        load_normal(16'h4000, 16'h0000, 16'h0000);
        load_normal(16'h8000, 16'h7fff, 16'hffff);
        send_face(1, 2, 3, 0, 0, 0);     // extreme coordinates, large cross product
        send_face(1, 4, 5, 0, 0, 0);     // unit triangle
        send_face(1, 1, 4, 0, 0, 0);     // repeated corner: degenerate
        send_face(0, 2, 3, 1, 1, 1);     // zero index
        send_face(1, 2, 6, 1, 1, 1);     // past the vertex count
        send_face(1024, 1, 2047, 1, 1, 1);
        send_item(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff,
                  2047, 2047, 2047, 2047, 2047, 2047);

        write_source(1'b1);
        send_face(1, 2, 3, 1, 2, 1);
        send_face(1, 2, 3, 0, 2, 1);     // bad normal index
        send_face(5, 4, 3, 2, 2, 3);     // normal past the count

        // Hold off until every corner is out.
        wait_drain();
        random_phase(110);
        write_source(1'b0);
        random_phase(110);

        send_face(1024, 1, 512, 1024, 1, 1);
        random_phase(100);
        write_source(1'b1);
        send_face(1024, 1024, 1024, 1024, 1024, 1024);
        random_phase(80);
        quiet_tail = 1'b1;
        random_phase(40);

        wait_drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
